[design/jtmd_pkg.sv]
// ----------------------------------------------------------------------------
// jtmd_pkg
// Shared types and constants of the joystick to mouse delta converter.
// ----------------------------------------------------------------------------
package jtmd_pkg;

    localparam int DEAD_ZONE     = 40;
    localparam int STEADY_WINDOW = 10;
    localparam int DRIFT_LIMIT   = 200;
    localparam int FULL_SCALE    = 127;
    localparam int ORIGIN_RESET  = 2048;
    localparam int UPPER_RESET   = 4096;

    // full scale is 2**GAIN_SHIFT - 1, so the gain is a shift and a subtract
    localparam int GAIN_SHIFT = 7;
    localparam int MOVE_W     = 8;
    localparam int MAG_W      = MOVE_W - 1;
    localparam int BUTTON_W   = 3;
    localparam int CFG_ADDR_W = 3;
    localparam int OUT_DATA_W = ((2 * MOVE_W + BUTTON_W + 7) / 8) * 8;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_X_ORIGIN = 3'd0,
        REG_Y_ORIGIN = 3'd1,
        REG_X_UPPER  = 3'd2,
        REG_X_LOWER  = 3'd3,
        REG_Y_UPPER  = 3'd4,
        REG_Y_LOWER  = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic load_in;
        logic track;
        logic prep;
        logic axis;
        logic store;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
    } dp_status_t;

endpackage

[design/jtmd_div.sv]
// ----------------------------------------------------------------------------
// jtmd_div
// Restoring serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module jtmd_div #(
    parameter int NUM_W = 19,
    parameter int DEN_W = 13
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [NUM_W-1:0] quot,
    output logic             done
);

    localparam int CNT_W = $clog2(NUM_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_W - 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [NUM_W-1:0] quo_reg;

    logic [DEN_W:0]   rem_shift;
    logic [DEN_W:0]   rem_sub;
    logic             fits;
    logic [DEN_W-1:0] rem_next;
    logic [NUM_W-1:0] quo_next;

    always_comb begin
        rem_shift = {rem_reg, quo_reg[NUM_W-1]};
        rem_sub   = rem_shift - {1'b0, den_reg};
        fits      = rem_shift >= {1'b0, den_reg};
        rem_next  = fits ? rem_sub[DEN_W-1:0] : rem_shift[DEN_W-1:0];
        quo_next  = {quo_reg[NUM_W-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= '0;
                quo_reg  <= num;
                den_reg  <= den;
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                quo_reg <= quo_next;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quot = quo_reg;
    assign done = done_reg;

endmodule

[design/jtmd_datapath.sv]
// ----------------------------------------------------------------------------
// jtmd_datapath
// Configuration, origin drift tracking, dead zone and scaling for both axes.
// ----------------------------------------------------------------------------
module jtmd_datapath #(
    parameter int SAMPLE_BITS    = 12,
    parameter int STABLE_SAMPLES = 50,
    parameter int IN_DATA_W      = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  jtmd_pkg::dp_cmd_t                   cmd,
    output jtmd_pkg::dp_status_t                status,
    input  logic [IN_DATA_W-1:0]                s_tdata,
    input  logic                                cfg_we,
    input  logic [jtmd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [SAMPLE_BITS:0]                cfg_wdata,
    output logic [jtmd_pkg::OUT_DATA_W-1:0]     m_tdata
);

    localparam int SB    = SAMPLE_BITS;
    localparam int DW    = SB + 2;
    localparam int SW    = SB + 3;
    localparam int NUM_W = SB + jtmd_pkg::GAIN_SHIFT;
    localparam int DEN_W = SB + 1;
    localparam int CNT_W = (STABLE_SAMPLES > 1) ? $clog2(STABLE_SAMPLES + 1) : 1;
    localparam int MW    = jtmd_pkg::MOVE_W;
    localparam int BW    = jtmd_pkg::BUTTON_W;

    localparam logic [CNT_W-1:0]     CNT_LAST  = CNT_W'(STABLE_SAMPLES - 1);
    localparam logic [SB-1:0]        ORG_RST   = SB'(jtmd_pkg::ORIGIN_RESET);
    localparam logic [SB:0]          UPPER_RST = (SB + 1)'(jtmd_pkg::UPPER_RESET);
    localparam logic signed [DW-1:0] WIN_S     = DW'(jtmd_pkg::STEADY_WINDOW);
    localparam logic signed [DW-1:0] DRIFT_S   = DW'(jtmd_pkg::DRIFT_LIMIT);
    localparam logic signed [DW-1:0] DZ_S      = DW'(jtmd_pkg::DEAD_ZONE);
    localparam logic [NUM_W-1:0]     FS_Q      = NUM_W'(jtmd_pkg::FULL_SCALE);
    localparam logic [jtmd_pkg::MAG_W-1:0] FS_M = jtmd_pkg::MAG_W'(jtmd_pkg::FULL_SCALE);

    typedef enum logic [1:0] {
        MODE_ZERO,
        MODE_FULL,
        MODE_DIV
    } scale_mode_t;

    // per axis state, index 0 is X and 1 is Y
    logic [SB-1:0]    samp_reg  [2];
    logic [SB-1:0]    live_reg  [2];
    logic [SB-1:0]    cand_reg  [2];
    logic [CNT_W-1:0] count_reg [2];
    logic [SB:0]      upper_reg [2];
    logic [SB-1:0]    lower_reg [2];
    logic [MW-1:0]    res_reg   [2];
    logic [BW-1:0]    btn_reg;
    logic [jtmd_pkg::OUT_DATA_W-1:0] m_data_reg;

    logic [SB-1:0]    live_next  [2];
    logic [SB-1:0]    cand_next  [2];
    logic [CNT_W-1:0] count_next [2];

    scale_mode_t      mode_reg;
    logic             neg_reg;

    // ---------------------------------------------------------------- drift
    for (genvar g = 0; g < 2; g++) begin : g_track
        logic signed [DW-1:0] d_cand;
        logic signed [DW-1:0] d_live;
        logic                 steady;
        logic                 near_live;

        always_comb begin
            d_cand    = $signed({2'b00, samp_reg[g]}) - $signed({2'b00, cand_reg[g]});
            d_live    = $signed({2'b00, cand_reg[g]}) - $signed({2'b00, live_reg[g]});
            steady    = (d_cand < WIN_S) && (d_cand > -WIN_S);
            near_live = (d_live < DRIFT_S) && (d_live > -DRIFT_S);
            live_next[g]  = live_reg[g];
            cand_next[g]  = cand_reg[g];
            count_next[g] = count_reg[g] + 1'b1;
            if (!steady) begin
                // restart on the new sample
                cand_next[g]  = samp_reg[g];
                count_next[g] = '0;
            end else if (count_reg[g] == CNT_LAST) begin
                if (near_live) begin
                    live_next[g] = cand_reg[g];
                end else begin
                    cand_next[g] = samp_reg[g];
                end
                count_next[g] = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 2; i++) begin
                live_reg[i]  <= ORG_RST;
                cand_reg[i]  <= ORG_RST;
                count_reg[i] <= '0;
                upper_reg[i] <= UPPER_RST;
                lower_reg[i] <= '0;
            end
        end else if (cfg_we) begin
            unique case (jtmd_pkg::cfg_reg_t'(cfg_addr))
                jtmd_pkg::REG_X_ORIGIN: begin
                    live_reg[0]  <= cfg_wdata[SB-1:0];
                    cand_reg[0]  <= cfg_wdata[SB-1:0];
                    count_reg[0] <= '0;
                end
                jtmd_pkg::REG_Y_ORIGIN: begin
                    live_reg[1]  <= cfg_wdata[SB-1:0];
                    cand_reg[1]  <= cfg_wdata[SB-1:0];
                    count_reg[1] <= '0;
                end
                jtmd_pkg::REG_X_UPPER: upper_reg[0] <= cfg_wdata;
                jtmd_pkg::REG_X_LOWER: lower_reg[0] <= cfg_wdata[SB-1:0];
                jtmd_pkg::REG_Y_UPPER: upper_reg[1] <= cfg_wdata;
                jtmd_pkg::REG_Y_LOWER: lower_reg[1] <= cfg_wdata[SB-1:0];
                default: ;
            endcase
        end else if (cmd.track) begin
            for (int i = 0; i < 2; i++) begin
                live_reg[i]  <= live_next[i];
                cand_reg[i]  <= cand_next[i];
                count_reg[i] <= count_next[i];
            end
        end
    end

    // ---------------------------------------------------------------- input
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            samp_reg[0] <= s_tdata[SB-1:0];
            samp_reg[1] <= s_tdata[2*SB-1:SB];
            btn_reg     <= s_tdata[2*SB+BW-1:2*SB];
        end
    end

    // ---------------------------------------------------------------- scale
    logic [SB-1:0]        s_a;
    logic [SB-1:0]        l_a;
    logic [SB:0]          u_a;
    logic [SB-1:0]        lo_a;
    logic signed [DW-1:0] delta;
    logic signed [DW-1:0] delta_mag;
    logic signed [SW-1:0] span;
    logic                 above;
    logic                 below;
    logic [SB-1:0]        mag;
    logic [NUM_W-1:0]     num;
    logic [DEN_W-1:0]     den;
    scale_mode_t          mode_next;

    always_comb begin
        s_a   = cmd.axis ? samp_reg[1]  : samp_reg[0];
        l_a   = cmd.axis ? live_reg[1]  : live_reg[0];
        u_a   = cmd.axis ? upper_reg[1] : upper_reg[0];
        lo_a  = cmd.axis ? lower_reg[1] : lower_reg[0];
        delta = $signed({2'b00, s_a}) - $signed({2'b00, l_a});
        above = delta > DZ_S;
        below = delta < -DZ_S;
        if (above) begin
            span = $signed({2'b00, u_a}) - $signed({3'b000, l_a});
        end else begin
            span = $signed({3'b000, l_a}) - $signed({3'b000, lo_a});
        end
        delta_mag = below ? -delta : delta;
        mag       = delta_mag[SB-1:0];
        num       = (NUM_W'(mag) << jtmd_pkg::GAIN_SHIFT) - NUM_W'(mag);
        den       = span[DEN_W-1:0];
        if (!above && !below) begin
            mode_next = MODE_ZERO;
        end else if (span[SW-1] || (span == '0)) begin
            // bound on the wrong side of the origin: saturate
            mode_next = MODE_FULL;
        end else begin
            mode_next = MODE_DIV;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.prep) begin
            mode_reg <= mode_next;
            neg_reg  <= below;
        end
    end

    logic [NUM_W-1:0] quot;
    logic             div_done;

    jtmd_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.prep),
        .num     (num),
        .den     (den),
        .quot    (quot),
        .done    (div_done)
    );

    assign status.div_done = div_done;

    logic [jtmd_pkg::MAG_W-1:0] mag_out;
    logic [MW-1:0]              mag_ext;
    logic [MW-1:0]              res_next;

    always_comb begin
        case (mode_reg)
            MODE_ZERO: mag_out = '0;
            MODE_FULL: mag_out = FS_M;
            MODE_DIV:  mag_out = (quot > FS_Q) ? FS_M : quot[jtmd_pkg::MAG_W-1:0];
            default:   mag_out = '0;
        endcase
        mag_ext = {1'b0, mag_out};
        // Y is inverted
        res_next = (neg_reg ^ cmd.axis) ? -mag_ext : mag_ext;
    end

    always_ff @(posedge aclk) begin
        if (cmd.store) begin
            if (cmd.axis) begin
                res_reg[1] <= res_next;
            end else begin
                res_reg[0] <= res_next;
            end
        end
        if (cmd.emit) begin
            m_data_reg <= jtmd_pkg::OUT_DATA_W'({btn_reg, res_reg[1], res_reg[0]});
        end
    end

    assign m_tdata = m_data_reg;

endmodule

[design/jtmd_ctrl.sv]
// ----------------------------------------------------------------------------
// jtmd_ctrl
// Sequencer: accept a word, track drift, scale X then Y, hand over the result.
// ----------------------------------------------------------------------------
module jtmd_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output jtmd_pkg::dp_cmd_t    cmd,
    input  jtmd_pkg::dp_status_t status
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TRACK,
        ST_PREP,
        ST_DIV,
        ST_EMIT
    } state_t;

    state_t state_reg;
    logic   axis_reg;
    logic   m_valid_reg;

    always_comb begin
        cmd         = '0;
        cmd.load_in = (state_reg == ST_IDLE) && s_tvalid;
        cmd.track   = (state_reg == ST_TRACK);
        cmd.prep    = (state_reg == ST_PREP);
        cmd.axis    = axis_reg;
        cmd.store   = (state_reg == ST_DIV) && status.div_done;
        // output register frees up when its word is taken
        cmd.emit    = (state_reg == ST_EMIT) && (!m_valid_reg || m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            axis_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        state_reg <= ST_TRACK;
                    end
                end
                ST_TRACK: begin
                    axis_reg  <= 1'b0;
                    state_reg <= ST_PREP;
                end
                ST_PREP: state_reg <= ST_DIV;
                ST_DIV: begin
                    if (status.div_done) begin
                        if (axis_reg) begin
                            state_reg <= ST_EMIT;
                        end else begin
                            axis_reg  <= 1'b1;
                            state_reg <= ST_PREP;
                        end
                    end
                end
                ST_EMIT: begin
                    if (cmd.emit) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;

endmodule

[design/joystick_to_mouse_delta_top.sv]
// ----------------------------------------------------------------------------
// joystick_to_mouse_delta_top
// Turns a pair of joystick samples and three buttons into one mouse report.
// Each input word carries an X and a Y sample and the button levels; each
// axis follows slow drift of its rest position, applies a +-40 dead zone,
// scales the offset by 127 over the span to the configured bound and clamps
// to +-127, Y inverted. One report leaves per word. Each report is scaled
// by the serial divider, which yields one quotient bit a cycle and serves X
// and then Y. A word is taken only once the previous one has been through
// both axes; the next word can be accepted in the cycle the previous report
// is presented. The next word is taken once the block is back in idle, even
// while the previous report still waits in the output register.
// Registers are written through cfg_wdata/cfg_addr/cfg_we while idle; this
// binds the user, the block itself does not enforce it.
// ----------------------------------------------------------------------------
module joystick_to_mouse_delta_top #(
    parameter int SAMPLE_BITS    = 12,
    parameter int STABLE_SAMPLES = 50
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // sample_x, sample_y, left_pressed, right_pressed, middle_pin
    input  logic [((2 * SAMPLE_BITS + jtmd_pkg::BUTTON_W + 7) / 8) * 8 - 1:0] s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // move_x, move_y, button_bits
    output logic [jtmd_pkg::OUT_DATA_W-1:0]     m_tdata,
    input  logic                                cfg_we,
    input  logic [jtmd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [SAMPLE_BITS:0]                cfg_wdata
);

    localparam int IN_DATA_W = ((2 * SAMPLE_BITS + jtmd_pkg::BUTTON_W + 7) / 8) * 8;
    localparam int MW        = jtmd_pkg::MOVE_W;

    jtmd_pkg::dp_cmd_t    cmd;
    jtmd_pkg::dp_status_t status;

    jtmd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    jtmd_datapath #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .STABLE_SAMPLES (STABLE_SAMPLES),
        .IN_DATA_W      (IN_DATA_W)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .m_tdata   (m_tdata)
    );

`ifndef SYNTHESIS
    a_accept_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> cmd.track)
        else $error("accepted word not followed by drift update");

    a_div_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        status.div_done |-> !s_tready)
        else $error("divider finished while idle");

    a_emit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |=> m_tvalid)
        else $error("report loaded but not presented");

    a_no_minus_128: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[MW-1:0] != {1'b1, {(MW-1){1'b0}}})
                  && (m_tdata[2*MW-1:MW] != {1'b1, {(MW-1){1'b0}}}))
        else $error("movement outside clamp range");
`endif

endmodule

[tb/sv/report_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// report_checker
// Follows register writes and input words of the joystick converter, keeps
// its own copy of the drift tracker and axis scaling, and compares every
// mouse report that leaves the block with the oldest predicted one.
// ----------------------------------------------------------------------------
module report_checker #(
    parameter int STABLE_RUN = 50
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    // sample_x, sample_y, left_pressed, right_pressed, middle_pin
    input  logic [31:0]                         s_tdata,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    // move_x, move_y, button_bits
    input  logic [jtmd_pkg::OUT_DATA_W-1:0]     m_tdata,
    input  logic                                cfg_we,
    input  logic [jtmd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [12:0]                         cfg_wdata,
    output int                                  mismatches,
    output int                                  outstanding
);

    typedef struct packed {
        logic [11:0] live;
        logic [11:0] cand;
        logic [5:0]  run;
        logic [12:0] upper;
        logic [11:0] lower;
    } axis_track_t;

    typedef struct packed {
        logic [7:0] move_x;
        logic [7:0] move_y;
        logic [2:0] buttons;
    } mouse_report_t;

    axis_track_t   x_axis;
    axis_track_t   y_axis;
    mouse_report_t expected_reports[$];

    function automatic int distance(input int a, input int b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic axis_track_t load_origin(input axis_track_t a, input logic [11:0] o);
        a.live = o;
        a.cand = o;
        a.run  = '0;
        return a;
    endfunction

    function automatic axis_track_t follow_drift(input axis_track_t a, input logic [11:0] s);
        if (distance(int'(s), int'(a.cand)) >= jtmd_pkg::STEADY_WINDOW) begin
            a.run  = '0;
            a.cand = s;
            return a;
        end
        a.run = a.run + 6'd1;
        if (int'(a.run) >= STABLE_RUN) begin
            // adopt the settled candidate only if it has not wandered too far
            if (distance(int'(a.cand), int'(a.live)) < jtmd_pkg::DRIFT_LIMIT)
                a.live = a.cand;
            else
                a.cand = s;
            a.run = '0;
        end
        return a;
    endfunction

    function automatic int scale_offset(input axis_track_t a, input logic [11:0] s);
        int delta;
        int span;
        int q;
        delta = int'(s) - int'(a.live);
        if (delta > jtmd_pkg::DEAD_ZONE)
            span = int'(a.upper) - int'(a.live);
        else if (delta < -jtmd_pkg::DEAD_ZONE)
            span = int'(a.live) - int'(a.lower);
        else
            return 0;
        // a bound on the wrong side of the origin means full deflection
        if (span <= 0)
            return (delta > 0) ? jtmd_pkg::FULL_SCALE : -jtmd_pkg::FULL_SCALE;
        q = (delta * jtmd_pkg::FULL_SCALE) / span;
        if (q > jtmd_pkg::FULL_SCALE)
            q = jtmd_pkg::FULL_SCALE;
        if (q < -jtmd_pkg::FULL_SCALE)
            q = -jtmd_pkg::FULL_SCALE;
        return q;
    endfunction

    task automatic check_field(input string field, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s expected %0d got %0d", $time, field, $signed(want), $signed(got));
        end
    endtask

    always @(posedge aclk) begin
        logic [11:0]   sx;
        logic [11:0]   sy;
        mouse_report_t next_report;
        mouse_report_t want;
        if (!aresetn) begin
            x_axis       = load_origin('0, 12'(jtmd_pkg::ORIGIN_RESET));
            y_axis       = load_origin('0, 12'(jtmd_pkg::ORIGIN_RESET));
            x_axis.upper = 13'(jtmd_pkg::UPPER_RESET);
            y_axis.upper = 13'(jtmd_pkg::UPPER_RESET);
            expected_reports.delete();
            mismatches   = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    jtmd_pkg::REG_X_ORIGIN: x_axis = load_origin(x_axis, cfg_wdata[11:0]);
                    jtmd_pkg::REG_Y_ORIGIN: y_axis = load_origin(y_axis, cfg_wdata[11:0]);
                    jtmd_pkg::REG_X_UPPER:  x_axis.upper = cfg_wdata;
                    jtmd_pkg::REG_X_LOWER:  x_axis.lower = cfg_wdata[11:0];
                    jtmd_pkg::REG_Y_UPPER:  y_axis.upper = cfg_wdata;
                    jtmd_pkg::REG_Y_LOWER:  y_axis.lower = cfg_wdata[11:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                sx = s_tdata[11:0];
                sy = s_tdata[23:12];
                x_axis = follow_drift(x_axis, sx);
                y_axis = follow_drift(y_axis, sy);
                next_report.move_x  = 8'(scale_offset(x_axis, sx));
                next_report.move_y  = 8'(-scale_offset(y_axis, sy));
                next_report.buttons = s_tdata[26:24];
                expected_reports.push_back(next_report);
            end
            if (m_tvalid && m_tready) begin
                if (expected_reports.size() == 0) begin
                    mismatches++;
                    $display("%0t: report 0x%h arrived with none expected", $time, m_tdata);
                end else begin
                    want = expected_reports.pop_front();
                    check_field("move_x", want.move_x, m_tdata[7:0]);
                    check_field("move_y", want.move_y, m_tdata[15:8]);
                    check_field("button_bits", {5'b0, want.buttons}, {5'b0, m_tdata[18:16]});
                end
            end
        end
        outstanding = expected_reports.size();
    end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives joystick sample words and register settings into the converter,
// with random sender gaps and receiver stalls, and reports the verdict of
// the report checker.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int STABLE_RUN     = 50;
    localparam int PHASE_ITEMS    = 130;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam logic [jtmd_pkg::CFG_ADDR_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [jtmd_pkg::CFG_ADDR_W-1:0] REG_SPARE_B = 3'd7;

    logic                              aclk;
    logic                              aresetn   = 1'b0;
    logic                              s_tvalid  = 1'b0;
    logic                              s_tready;
    logic [31:0]                       s_tdata   = '0;
    logic                              m_tvalid;
    logic                              m_tready  = 1'b0;
    logic [jtmd_pkg::OUT_DATA_W-1:0]   m_tdata;
    logic                              cfg_we    = 1'b0;
    logic [jtmd_pkg::CFG_ADDR_W-1:0]   cfg_addr  = '0;
    logic [12:0]                       cfg_wdata = '0;

    int mismatches;
    int outstanding;
    int send_gap_pct = 0;
    int stall_pct    = 0;
    int quiet_cycles = 0;
    int rest_x       = jtmd_pkg::ORIGIN_RESET;
    int rest_y       = jtmd_pkg::ORIGIN_RESET;

    joystick_to_mouse_delta_top #(
        .SAMPLE_BITS    (12),
        .STABLE_SAMPLES (STABLE_RUN)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    report_checker #(
        .STABLE_RUN (STABLE_RUN)
    ) u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(negedge aclk) begin
        m_tready <= (int'($urandom_range(0, 99)) >= stall_pct);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("** joystick_to_mouse_delta_top: FAILED **");
            $finish;
        end
    end

    function automatic logic [11:0] pin(input int v);
        if (v < 0)
            return 12'd0;
        if (v > 4095)
            return 12'd4095;
        return 12'(v);
    endfunction

    function automatic int jitter();
        // mostly inside the steady window, now and then just outside it
        if ($urandom_range(0, 19) == 0)
            return int'($urandom_range(0, 30)) - 15;
        return int'($urandom_range(0, 18)) - 9;
    endfunction

    function automatic logic [11:0] deflect(input int rest);
        case ($urandom_range(0, 2))
            0:       return 12'($urandom);
            1:       return pin(rest + int'($urandom_range(0, 120)) - 60);
            default: return $urandom_range(0, 1) ? 12'd4095 : 12'd0;
        endcase
    endfunction

    // entered just after a falling edge; leaves the word valid until the next one
    task automatic send_word(input logic [11:0] sx, input logic [11:0] sy,
                             input logic [2:0] buttons);
        while (send_gap_pct != 0 && int'($urandom_range(0, 99)) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, buttons, sy, sx};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // drop valid and hold until every report has come back
    task automatic settle();
        s_tvalid <= 1'b0;
        while (outstanding != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [jtmd_pkg::CFG_ADDR_W-1:0] addr,
                             input logic [12:0] data);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(negedge aclk);
    endtask

    task automatic program_regs(input logic [12:0] xo, input logic [12:0] yo,
                                input logic [12:0] xu, input logic [12:0] xl,
                                input logic [12:0] yu, input logic [12:0] yl);
        write_reg(jtmd_pkg::REG_X_ORIGIN, xo);
        write_reg(jtmd_pkg::REG_Y_ORIGIN, yo);
        write_reg(jtmd_pkg::REG_X_UPPER, xu);
        write_reg(jtmd_pkg::REG_X_LOWER, xl);
        write_reg(jtmd_pkg::REG_Y_UPPER, yu);
        write_reg(jtmd_pkg::REG_Y_LOWER, yl);
        write_reg(REG_SPARE_A, 13'h1fff);
        write_reg(REG_SPARE_B, 13'h0aaa);
        cfg_we <= 1'b0;
        @(negedge aclk);
        rest_x = int'(xo[11:0]);
        rest_y = int'(yo[11:0]);
    endtask

    task automatic run_phase(input int items);
        int sent;
        int len;
        bit y_wild;
        sent = 0;
        while (sent < items) begin
            if ($urandom_range(0, 9) <= 5) begin
                // rest near a drifted point long enough for the origin to follow
                rest_x = int'(pin(rest_x + int'($urandom_range(0, 500)) - 250));
                rest_y = int'(pin(rest_y + int'($urandom_range(0, 500)) - 250));
                len    = $urandom_range(45, 75);
                y_wild = ($urandom_range(0, 3) == 0);
                for (int i = 0; i < len && sent < items; i++) begin
                    send_word(pin(rest_x + jitter()),
                              y_wild ? deflect(rest_y) : pin(rest_y + jitter()),
                              3'($urandom));
                    sent++;
                end
            end else begin
                len = $urandom_range(3, 15);
                for (int i = 0; i < len && sent < items; i++) begin
                    send_word(deflect(rest_x), deflect(rest_y), 3'($urandom));
                    sent++;
                end
            end
        end
    endtask

    initial begin
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // dead zone edges, extremes and every button combination
        program_regs(13'd2048, 13'd2048, 13'd4096, 13'd0, 13'd4096, 13'd0);
        send_word(12'd2048, 12'd2048, 3'd0);
        send_word(12'd2088, 12'd2008, 3'd1);
        send_word(12'd2008, 12'd2088, 3'd2);
        send_word(12'd2089, 12'd2007, 3'd3);
        send_word(12'd2007, 12'd2089, 3'd4);
        send_word(12'd4095, 12'd0, 3'd5);
        send_word(12'd0, 12'd4095, 3'd6);
        send_word(12'd4095, 12'd4095, 3'd7);
        send_word(12'd0, 12'd0, 3'd0);
        settle();

        // zero and negative spans, clamping, bits above the register widths
        send_gap_pct = 32;
        stall_pct    = 32;
        program_regs(13'h1800, 13'd2048, 13'd2048, 13'h1bb8, 13'd2100, 13'd2047);
        send_word(12'd3000, 12'd4095, 3'd7);
        send_word(12'd100, 12'd0, 3'd2);
        send_word(12'd2089, 12'd2089, 3'd5);
        send_word(12'd2007, 12'd2007, 3'd1);
        send_word(12'd4095, 12'd2048, 3'd4);
        settle();

        for (int p = 0; p < 8; p++) begin
            case (p % 4)
                0: begin send_gap_pct = 0;  stall_pct = 0;  end
                1: begin send_gap_pct = 52; stall_pct = 0;  end
                2: begin send_gap_pct = 0;  stall_pct = 52; end
                default: begin send_gap_pct = 32; stall_pct = 32; end
            endcase
            case (p)
                0: program_regs(13'd2048, 13'd2048, 13'd4096, 13'd0, 13'd4096, 13'd0);
                1: program_regs(13'd100, 13'd3900, 13'd8191, 13'd0, 13'd4095, 13'd4095);
                2: program_regs(13'd2000, 13'd1500, 13'd2000, 13'd1999, 13'd1800, 13'd1200);
                4: program_regs(13'd4095, 13'd0, 13'd4096, 13'd0, 13'd0, 13'd0);
                6: program_regs(13'd2048, 13'd2048, 13'd3000, 13'd1000, 13'd3500, 13'd500);
                default: program_regs(13'($urandom), 13'($urandom), 13'($urandom),
                                      13'($urandom), 13'($urandom), 13'($urandom));
            endcase
            run_phase(PHASE_ITEMS);
            settle();
        end

        repeat (60) @(negedge aclk);
        if (mismatches == 0 && outstanding == 0)
            $display("** joystick_to_mouse_delta_top: PASSED **");
        else
            $display("** joystick_to_mouse_delta_top: FAILED **");
        $finish;
    end

endmodule
